FILE: src/hbts_pkg.sv
// shared types and constants of the height blend texture splat core
// no dependencies; used by the top level, controller, datapath and testbench
`default_nettype none

package hbts_pkg;

  // parameter defaults
  localparam int MAX_TILES_DEF    = 4;
  localparam int TILE_MAX_DIM_DEF = 64;

  // field widths
  localparam int COORD_W   = 16;
  localparam int HEIGHT_W  = 24;
  localparam int RANGE_W   = 24;
  localparam int RGB_W     = 24;
  localparam int CHAN_W    = 8;
  localparam int NUM_CH    = 3;
  localparam int TEXADDR_W = 12;
  localparam int SEL_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int NT_W      = 3;
  localparam int DIM_CFG_W = 7;

  // weight is q0.16 plus the exact 1.0 value
  localparam int FRAC_W   = 16;
  localparam int WEIGHT_W = FRAC_W + 1;
  localparam int STEP_W   = $clog2(WEIGHT_W);
  localparam int ONE_Q8   = 256;
  localparam int CHAN_MAX = 255;

  // apb port
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // register indexes
  localparam logic [1:0] REG_NUM_TILES   = 2'd0;
  localparam logic [1:0] REG_RANGE       = 2'd1;
  localparam logic [1:0] REG_TILE_WIDTH  = 2'd2;
  localparam logic [1:0] REG_TILE_HEIGHT = 2'd3;

  // request types
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_BLEND = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SAT = 2'd1;

  typedef struct packed {
    logic [NT_W-1:0]      num_tiles;
    logic [RANGE_W-1:0]   range_per_tile;
    logic [DIM_CFG_W-1:0] tile_width;
    logic [DIM_CFG_W-1:0] tile_height;
  } hbts_cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic load_wr;
    logic mod_step;
    logic addr_calc;
    logic band_a;
    logic band_b;
    logic div_step;
    logic div_first;
    logic mul;
    logic acc;
    logic tile_next;
    logic finish;
  } hbts_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic            band_zero;
    logic [NT_W-1:0] tiles_used;
  } hbts_stat_t;

endpackage

`default_nettype wire

FILE: src/height_blend_texture_splat_core.sv
// top level of the height blend texture splat core: apb register file,
// controller and datapath; depends on hbts_pkg, hbts_ctrl, hbts_dp
`default_nettype none

// Height blend texture splat core. A request is taken when start is high and
// busy is low. A load request (in_req_type 0) writes one texel into the
// texel store and returns a zero result after its load state. A blend
// request (in_req_type 1) returns one blended pixel after these steps: x and
// y are wrapped one bit a step over every coordinate bit, the texel address
// is formed, and each tile in use runs its band test and texel read; a tile
// inside its band (at most two at any height) also runs the bit-serial weight
// divider, one quotient bit a step, plus a multiply and an accumulate. One
// request is in work at a time. Every result is shown for exactly one cycle
// with out_valid high and the receiver cannot stall it; busy is already low
// in that cycle, so the next request can be taken right away. Configuration
// must be written over the apb port only while the core is idle; the core
// does not enforce this. pready is always high. Texels that were never
// loaded read back as undefined data.

module height_blend_texture_splat_core #(
  parameter int MAX_TILES    = hbts_pkg::MAX_TILES_DEF,
  parameter int TILE_MAX_DIM = hbts_pkg::TILE_MAX_DIM_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // apb configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [hbts_pkg::APB_AW-1:0]    paddr,
  input  wire logic [hbts_pkg::APB_DW-1:0]    pwdata,
  output logic      [hbts_pkg::APB_DW-1:0]    prdata,
  output logic                                pready,
  // request channel
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           in_req_type,
  input  wire logic [hbts_pkg::SEL_W-1:0]     in_tile_sel,
  input  wire logic [hbts_pkg::TEXADDR_W-1:0] in_texel_addr,
  input  wire logic [hbts_pkg::RGB_W-1:0]     in_texel_rgb,
  input  wire logic [hbts_pkg::HEIGHT_W-1:0]  in_height,
  input  wire logic [hbts_pkg::COORD_W-1:0]   in_pixel_x,
  input  wire logic [hbts_pkg::COORD_W-1:0]   in_pixel_y,
  // result channel
  output logic                                out_valid,
  output logic      [hbts_pkg::RGB_W-1:0]     out_pixel_rgb,
  output logic      [hbts_pkg::STATUS_W-1:0]  out_status
);

  hbts_pkg::hbts_cfg_t  cfg_r;
  hbts_pkg::hbts_cmd_t  cmd;
  hbts_pkg::hbts_stat_t stat;
  logic                 cfg_wr;
  logic [1:0]           reg_idx;

  // register index from the word address
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // register file, to be written only while idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_tiles      <= hbts_pkg::NT_W'(1);
      cfg_r.range_per_tile <= hbts_pkg::RANGE_W'(25600);
      cfg_r.tile_width     <= hbts_pkg::DIM_CFG_W'(64);
      cfg_r.tile_height    <= hbts_pkg::DIM_CFG_W'(64);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        hbts_pkg::REG_NUM_TILES:
          cfg_r.num_tiles <= pwdata[hbts_pkg::NT_W-1:0];
        hbts_pkg::REG_RANGE:
          cfg_r.range_per_tile <= pwdata[hbts_pkg::RANGE_W-1:0];
        hbts_pkg::REG_TILE_WIDTH:
          cfg_r.tile_width <= pwdata[hbts_pkg::DIM_CFG_W-1:0];
        hbts_pkg::REG_TILE_HEIGHT:
          cfg_r.tile_height <= pwdata[hbts_pkg::DIM_CFG_W-1:0];
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      hbts_pkg::REG_NUM_TILES:   prdata = hbts_pkg::APB_DW'(cfg_r.num_tiles);
      hbts_pkg::REG_RANGE:       prdata = hbts_pkg::APB_DW'(cfg_r.range_per_tile);
      hbts_pkg::REG_TILE_WIDTH:  prdata = hbts_pkg::APB_DW'(cfg_r.tile_width);
      hbts_pkg::REG_TILE_HEIGHT: prdata = hbts_pkg::APB_DW'(cfg_r.tile_height);
    endcase
  end

  // sequencer
  hbts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy),
    .done     (out_valid)
  );

  // wrap, weight, texel store and accumulation
  hbts_dp #(
    .MAX_TILES    (MAX_TILES),
    .TILE_MAX_DIM (TILE_MAX_DIM)
  ) u_dp (
    .clk           (clk),
    .cfg           (cfg_r),
    .cmd           (cmd),
    .in_tile_sel   (in_tile_sel),
    .in_texel_addr (in_texel_addr),
    .in_texel_rgb  (in_texel_rgb),
    .in_height     (in_height),
    .in_pixel_x    (in_pixel_x),
    .in_pixel_y    (in_pixel_y),
    .stat          (stat),
    .out_pixel_rgb (out_pixel_rgb),
    .out_status    (out_status)
  );

  // a taken request always leaves the core busy in the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken but core not busy");

  // one result per request, never two strobes back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // the core is idle again while its result is shown
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // weights stay within 0..1 so only ok or saturated is reported
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == hbts_pkg::STATUS_OK ||
                   out_status == hbts_pkg::STATUS_SAT))
    else $error("unexpected result status");

endmodule

`default_nettype wire

FILE: src/hbts_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module hbts_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: src/hbts_ctrl.sv
// sequencing state machine of the splat core
// depends on hbts_pkg for command and status structs
`default_nettype none

module hbts_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               req_type,
  input  wire hbts_pkg::hbts_stat_t stat,
  output hbts_pkg::hbts_cmd_t     cmd,
  output logic                    busy,
  output logic                    done
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_MOD, S_ADDR, S_BAND_A, S_BAND_B,
    S_DIV, S_MUL, S_ACC, S_NEXT, S_FINAL
  } state_t;

  state_t                          state_r;
  logic [hbts_pkg::STEP_W-1:0]     step_r;
  logic [hbts_pkg::NT_W-1:0]       tile_r;
  logic                            busy_r;
  logic                            done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      tile_r  <= '0;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            busy_r  <= 1'b1;
            step_r  <= '0;
            state_r <= (req_type == hbts_pkg::REQ_LOAD) ? S_LOAD : S_MOD;
          end
        end
        S_LOAD: begin
          busy_r  <= 1'b0;
          done_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        S_MOD: begin
          step_r <= step_r + 1'b1;
          if (step_r == hbts_pkg::STEP_W'(hbts_pkg::COORD_W - 1)) begin
            state_r <= S_ADDR;
          end
        end
        S_ADDR: begin
          tile_r  <= '0;
          state_r <= (stat.tiles_used == '0) ? S_FINAL : S_BAND_A;
        end
        S_BAND_A: state_r <= S_BAND_B;
        S_BAND_B: begin
          step_r  <= '0;
          state_r <= stat.band_zero ? S_NEXT : S_DIV;
        end
        S_DIV: begin
          step_r <= step_r + 1'b1;
          if (step_r == hbts_pkg::STEP_W'(hbts_pkg::WEIGHT_W - 1)) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: state_r <= S_ACC;
        S_ACC: state_r <= S_NEXT;
        S_NEXT: begin
          tile_r  <= tile_r + 1'b1;
          state_r <= (tile_r + 1'b1 == stat.tiles_used) ? S_FINAL : S_BAND_A;
        end
        S_FINAL: begin
          busy_r  <= 1'b0;
          done_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.capture   = (state_r == S_IDLE) && start;
    cmd.load_wr   = (state_r == S_LOAD);
    cmd.mod_step  = (state_r == S_MOD);
    cmd.addr_calc = (state_r == S_ADDR);
    cmd.band_a    = (state_r == S_BAND_A);
    cmd.band_b    = (state_r == S_BAND_B);
    cmd.div_step  = (state_r == S_DIV);
    cmd.div_first = (state_r == S_DIV) && (step_r == '0);
    cmd.mul       = (state_r == S_MUL);
    cmd.acc       = (state_r == S_ACC);
    cmd.tile_next = (state_r == S_NEXT);
    cmd.finish    = (state_r == S_FINAL);
  end

  assign busy = busy_r;
  assign done = done_r;

endmodule

`default_nettype wire

FILE: src/hbts_dp.sv
// datapath of the splat core: coordinate wrap, band weight divider,
// texel store and color accumulation; depends on hbts_pkg and hbts_ram
`default_nettype none

module hbts_dp #(
  parameter int MAX_TILES    = hbts_pkg::MAX_TILES_DEF,
  parameter int TILE_MAX_DIM = hbts_pkg::TILE_MAX_DIM_DEF
) (
  input  wire logic                            clk,
  input  wire hbts_pkg::hbts_cfg_t             cfg,
  input  wire hbts_pkg::hbts_cmd_t             cmd,
  input  wire logic [hbts_pkg::SEL_W-1:0]      in_tile_sel,
  input  wire logic [hbts_pkg::TEXADDR_W-1:0]  in_texel_addr,
  input  wire logic [hbts_pkg::RGB_W-1:0]      in_texel_rgb,
  input  wire logic [hbts_pkg::HEIGHT_W-1:0]   in_height,
  input  wire logic [hbts_pkg::COORD_W-1:0]    in_pixel_x,
  input  wire logic [hbts_pkg::COORD_W-1:0]    in_pixel_y,
  output hbts_pkg::hbts_stat_t                 stat,
  output logic      [hbts_pkg::RGB_W-1:0]      out_pixel_rgb,
  output logic      [hbts_pkg::STATUS_W-1:0]   out_status
);

  localparam int TILE_ENTRIES = TILE_MAX_DIM * TILE_MAX_DIM;
  localparam int STORE_DEPTH  = MAX_TILES * TILE_ENTRIES;
  localparam int MEM_AW       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int TA_W         = (TILE_ENTRIES > 1) ? $clog2(TILE_ENTRIES) : 1;
  localparam int DIM_W        = $clog2(TILE_MAX_DIM + 1);
  localparam int BAND_W       = hbts_pkg::RANGE_W + $clog2(MAX_TILES + 2) + 1;
  localparam int PROD_W       = hbts_pkg::WEIGHT_W + hbts_pkg::CHAN_W;
  localparam int SUM_W        = PROD_W + $clog2(MAX_TILES + 1);
  localparam int REM_W        = hbts_pkg::RANGE_W + 1;
  localparam int CW           = hbts_pkg::CHAN_W;
  localparam int NCH          = hbts_pkg::NUM_CH;
  localparam logic [SUM_W-1:0] SAT_LIM =
    SUM_W'(hbts_pkg::CHAN_MAX) << hbts_pkg::FRAC_W;

  // captured request
  logic [hbts_pkg::SEL_W-1:0]     sel_r;
  logic [hbts_pkg::TEXADDR_W-1:0] taddr_r;
  logic [hbts_pkg::RGB_W-1:0]     trgb_r;
  logic [hbts_pkg::HEIGHT_W-1:0]  h_r;

  // wrap units
  logic [hbts_pkg::COORD_W-1:0]   xs_r, ys_r;
  logic [DIM_W-1:0]               xrem_r, yrem_r;
  logic [DIM_W-1:0]               tw_c, th_c;
  logic [DIM_W:0]                 xcand, ycand;
  logic [2*DIM_W-1:0]             addr_full;
  logic [TA_W-1:0]                addr_r;

  // band and divider
  logic signed [BAND_W-1:0]       lo_r, opt_r, hi_r;
  logic signed [BAND_W-1:0]       h_s, r_s, one_s, num_s, den_s;
  logic                           rising;
  logic [REM_W-1:0]               rem_r, cand;
  logic [hbts_pkg::RANGE_W-1:0]   den_r;
  logic                           ge;
  logic [hbts_pkg::WEIGHT_W-1:0]  q_r;

  // texel store
  logic [MEM_AW-1:0]              base_r;
  logic                           wr_en;
  logic [MEM_AW-1:0]              wr_addr;
  logic [hbts_pkg::RGB_W-1:0]     rd_data;
  logic [hbts_pkg::RGB_W-1:0]     texel_r;

  // accumulation
  logic [PROD_W-1:0]              prod_r [NCH];
  logic [SUM_W-1:0]               sum_r  [NCH];
  logic [CW-1:0]                  chan_v [NCH];
  logic [NCH-1:0]                 sat_v;

  // tile size, zero acts as one and large values stop at the maximum
  always_comb begin
    if (cfg.tile_width == '0) begin
      tw_c = DIM_W'(1);
    end else if (32'(cfg.tile_width) > TILE_MAX_DIM) begin
      tw_c = DIM_W'(TILE_MAX_DIM);
    end else begin
      tw_c = DIM_W'(cfg.tile_width);
    end
    if (cfg.tile_height == '0) begin
      th_c = DIM_W'(1);
    end else if (32'(cfg.tile_height) > TILE_MAX_DIM) begin
      th_c = DIM_W'(TILE_MAX_DIM);
    end else begin
      th_c = DIM_W'(cfg.tile_height);
    end
  end

  always_comb begin
    if (32'(cfg.num_tiles) > MAX_TILES) begin
      stat.tiles_used = hbts_pkg::NT_W'(MAX_TILES);
    end else begin
      stat.tiles_used = cfg.num_tiles;
    end
  end

  // restoring remainder, one coordinate bit a step
  assign xcand = {xrem_r, xs_r[hbts_pkg::COORD_W-1]};
  assign ycand = {yrem_r, ys_r[hbts_pkg::COORD_W-1]};
  assign addr_full = (2*DIM_W)'(yrem_r) * (2*DIM_W)'(tw_c) + (2*DIM_W)'(xrem_r);

  // band bounds
  assign h_s    = $signed(BAND_W'(h_r));
  assign r_s    = $signed(BAND_W'(cfg.range_per_tile));
  assign one_s  = $signed(BAND_W'(hbts_pkg::ONE_Q8));
  assign rising = h_s < opt_r;
  assign num_s  = rising ? (h_s - lo_r) : (hi_r - h_s);
  assign den_s  = rising ? (opt_r - lo_r) : (hi_r - opt_r);
  assign stat.band_zero = (h_s < lo_r) || (h_s > hi_r) || !(den_s > 0);

  // divider step, first step compares without shifting
  assign cand = cmd.div_first ? rem_r : {rem_r[REM_W-2:0], 1'b0};
  assign ge   = cand >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sel_r   <= in_tile_sel;
      taddr_r <= in_texel_addr;
      trgb_r  <= in_texel_rgb;
      h_r     <= in_height;
      xs_r    <= in_pixel_x;
      ys_r    <= in_pixel_y;
      xrem_r  <= '0;
      yrem_r  <= '0;
    end
    if (cmd.mod_step) begin
      xs_r   <= xs_r << 1;
      ys_r   <= ys_r << 1;
      xrem_r <= (xcand >= {1'b0, tw_c}) ? DIM_W'(xcand - {1'b0, tw_c}) : DIM_W'(xcand);
      yrem_r <= (ycand >= {1'b0, th_c}) ? DIM_W'(ycand - {1'b0, th_c}) : DIM_W'(ycand);
    end
    if (cmd.addr_calc) begin
      addr_r <= addr_full[TA_W-1:0];
      lo_r   <= '0;
      base_r <= '0;
      for (int c = 0; c < NCH; c++) begin
        sum_r[c] <= '0;
      end
    end
    if (cmd.band_a) begin
      opt_r <= lo_r + r_s - one_s;
      hi_r  <= lo_r + (r_s <<< 1) - one_s;
    end
    if (cmd.band_b) begin
      texel_r <= rd_data;
      rem_r   <= REM_W'(num_s[hbts_pkg::RANGE_W-1:0]);
      den_r   <= den_s[hbts_pkg::RANGE_W-1:0];
    end
    if (cmd.div_step) begin
      rem_r <= ge ? (cand - {1'b0, den_r}) : cand;
      q_r   <= {q_r[hbts_pkg::WEIGHT_W-2:0], ge};
    end
    if (cmd.mul) begin
      for (int c = 0; c < NCH; c++) begin
        prod_r[c] <= PROD_W'(q_r) * PROD_W'(texel_r[(NCH-1-c)*CW +: CW]);
      end
    end
    if (cmd.acc) begin
      for (int c = 0; c < NCH; c++) begin
        sum_r[c] <= sum_r[c] + SUM_W'(prod_r[c]);
      end
    end
    if (cmd.tile_next) begin
      lo_r   <= lo_r + r_s;
      base_r <= base_r + MEM_AW'(TILE_ENTRIES);
    end
    if (cmd.load_wr) begin
      out_pixel_rgb <= '0;
      out_status    <= hbts_pkg::STATUS_OK;
    end else if (cmd.finish) begin
      out_pixel_rgb <= {chan_v[0], chan_v[1], chan_v[2]};
      out_status    <= (sat_v != '0) ? hbts_pkg::STATUS_SAT : hbts_pkg::STATUS_OK;
    end
  end

  // saturate each channel at full scale
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      sat_v[c]  = sum_r[c] > SAT_LIM;
      chan_v[c] = sat_v[c] ? CW'(hbts_pkg::CHAN_MAX) : sum_r[c][hbts_pkg::FRAC_W +: CW];
    end
  end

  // out of range loads write nothing
  assign wr_en   = cmd.load_wr && (32'(sel_r) < MAX_TILES) && (32'(taddr_r) < TILE_ENTRIES);
  assign wr_addr = MEM_AW'(32'(sel_r) * TILE_ENTRIES + 32'(taddr_r));

  hbts_ram #(
    .WIDTH (hbts_pkg::RGB_W),
    .DEPTH (STORE_DEPTH)
  ) u_texels (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (trgb_r),
    .rd_en   (cmd.band_a),
    .rd_addr (base_r + MEM_AW'(addr_r)),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

FILE: test/testbench.sv
// self-checking testbench of height_blend_texture_splat_core: directed and random
// texel load and blend requests, each predicted in place and checked at the result port
// depends on hbts_pkg and the core sources only

module testbench;
  import hbts_pkg::*;

  localparam int TILE_ENTRIES  = TILE_MAX_DIM_DEF * TILE_MAX_DIM_DEF;
  localparam int STORE_ENTRIES = MAX_TILES_DEF * TILE_ENTRIES;
  localparam int RANDOM_ITEMS  = 550;
  localparam int PHASE_ITEMS   = 60;
  localparam int MAX_GAP       = 6;
  localparam int TAIL_CYCLES   = 100;
  localparam int CYCLE_LIMIT   = 400000;

  // one request as driven on the input ports, plus the idle cycles ahead of it
  typedef struct {
    logic                 req_type;
    logic [SEL_W-1:0]     tile_sel;
    logic [TEXADDR_W-1:0] texel_addr;
    logic [RGB_W-1:0]     texel_rgb;
    logic [HEIGHT_W-1:0]  height;
    logic [COORD_W-1:0]   pixel_x;
    logic [COORD_W-1:0]   pixel_y;
    int                   gap;
  } splat_req_t;

  typedef struct {
    logic [RGB_W-1:0]    rgb;
    logic [STATUS_W-1:0] status;
  } splat_pixel_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // apb side
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  wire  [APB_DW-1:0] prdata;
  wire               pready;

  // request side
  logic                 start         = 1'b0;
  wire                  busy;
  logic                 in_req_type   = 1'b0;
  logic [SEL_W-1:0]     in_tile_sel   = '0;
  logic [TEXADDR_W-1:0] in_texel_addr = '0;
  logic [RGB_W-1:0]     in_texel_rgb  = '0;
  logic [HEIGHT_W-1:0]  in_height     = '0;
  logic [COORD_W-1:0]   in_pixel_x    = '0;
  logic [COORD_W-1:0]   in_pixel_y    = '0;

  // result side
  wire                out_valid;
  wire [RGB_W-1:0]    out_pixel_rgb;
  wire [STATUS_W-1:0] out_status;

  height_blend_texture_splat_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_tile_sel   (in_tile_sel),
    .in_texel_addr (in_texel_addr),
    .in_texel_rgb  (in_texel_rgb),
    .in_height     (in_height),
    .in_pixel_x    (in_pixel_x),
    .in_pixel_y    (in_pixel_y),
    .out_valid     (out_valid),
    .out_pixel_rgb (out_pixel_rgb),
    .out_status    (out_status)
  );

  // requests waiting to be driven, and pixels waiting to come out
  splat_req_t   pending_reqs[$];
  splat_pixel_t expected_pixels[$];

  // shadow of the texel store as seen by taken requests
  logic [RGB_W-1:0] texel_store [STORE_ENTRIES];
  // entries that some queued load will have written; blends never read anything else
  bit               texel_loaded [STORE_ENTRIES];
  // shadow of the register file
  hbts_cfg_t        splat_cfg;

  int gap_max          = MAX_GAP;
  int queued_items     = 0;
  int loads_taken      = 0;
  int blends_taken     = 0;
  int results_checked  = 0;
  int mismatches       = 0;
  int settings_applied = 0;
  int cycle_count      = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // helpers shared by the predictor and the stimulus
  // ---------------------------------------------------------------------------

  // tile sizes of 0 act as 1, sizes above the store's dimension are clipped
  function automatic int unsigned dim_limit(input logic [DIM_CFG_W-1:0] d);
    if (d == 0) return 1;
    if (d > TILE_MAX_DIM_DEF) return TILE_MAX_DIM_DEF;
    return d;
  endfunction

  // tiles blended per pixel; num_tiles above the store's tile count is clipped
  function automatic int active_tiles();
    if (splat_cfg.num_tiles > MAX_TILES_DEF) return MAX_TILES_DEF;
    return splat_cfg.num_tiles;
  endfunction

  // ---------------------------------------------------------------------------
  // pixel predictor: triangular band weight per tile, weighted colour sum
  // ---------------------------------------------------------------------------
  function automatic splat_pixel_t predict_pixel(input splat_req_t r);
    splat_pixel_t      px;
    int unsigned       tw, th, addr;
    longint            hgt, rng, lo, opt, hi, num, den;
    longint unsigned   wgt;
    longint unsigned   sum [NUM_CH];
    logic [RGB_W-1:0]  texel;
    logic [CHAN_W-1:0] chan;
    px.rgb    = '0;
    px.status = STATUS_OK;
    // a load always answers with a zero pixel
    if (r.req_type == REQ_LOAD) return px;
    tw   = dim_limit(splat_cfg.tile_width);
    th   = dim_limit(splat_cfg.tile_height);
    addr = (r.pixel_y % th) * tw + (r.pixel_x % tw);
    hgt  = r.height;
    rng  = splat_cfg.range_per_tile;
    for (int c = 0; c < NUM_CH; c++) sum[c] = 0;
    for (int t = 0; t < active_tiles(); t++) begin
      texel = texel_store[t * TILE_ENTRIES + addr];
      // band of tile t: low, optimal one q8 unit below the next low, high one range on
      lo  = t * rng;
      opt = lo + rng - ONE_Q8;
      hi  = opt + rng;
      wgt = 0;
      if (hgt >= lo && hgt <= hi) begin
        if (hgt < opt) begin
          num = hgt - lo;
          den = opt - lo;
        end else begin
          num = hi - hgt;
          den = hi - opt;
        end
        // an empty slope (range of one unit or less) contributes nothing
        if (den > 0 && num >= 0) wgt = (((num > den) ? den : num) << FRAC_W) / den;
      end
      for (int c = 0; c < NUM_CH; c++)
        sum[c] += wgt * texel[RGB_W-1-CHAN_W*c -: CHAN_W];
    end
    for (int c = 0; c < NUM_CH; c++) begin
      if (sum[c] > (CHAN_MAX << FRAC_W)) begin
        chan      = CHAN_MAX;
        px.status = STATUS_SAT;
      end else begin
        chan = sum[c] >> FRAC_W;
      end
      px.rgb = {px.rgb[RGB_W-CHAN_W-1:0], chan};
    end
    return px;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // extremes of colour are common, the rest is random
  function automatic logic [RGB_W-1:0] pick_rgb();
    case ($urandom_range(0, 3))
      0:       return 24'hFFFFFF;
      1:       return '0;
      default: return $urandom_range(0, 24'hFFFFFF);
    endcase
  endfunction

  // full 16-bit coordinates or small ones that wrap a few times
  function automatic logic [COORD_W-1:0] pick_coord();
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 65535);
    return $urandom_range(0, 130);
  endfunction

  // mostly small tiles, with the empty, full and oversized settings mixed in
  function automatic logic [DIM_CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return TILE_MAX_DIM_DEF;
      2:       return $urandom_range(TILE_MAX_DIM_DEF + 1, 127);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // random content in every field; the fields a request does not use stay random
  function automatic splat_req_t noise_req();
    splat_req_t r;
    r.req_type   = $urandom_range(0, 1);
    r.tile_sel   = $urandom_range(0, 3);
    r.texel_addr = $urandom_range(0, 4095);
    r.texel_rgb  = $urandom_range(0, 24'hFFFFFF);
    r.height     = $urandom_range(0, 24'hFFFFFF);
    r.pixel_x    = $urandom_range(0, 65535);
    r.pixel_y    = $urandom_range(0, 65535);
    r.gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, gap_max);
    return r;
  endfunction

  task automatic queue_load(input logic [SEL_W-1:0] tile, input logic [TEXADDR_W-1:0] addr,
                            input logic [RGB_W-1:0] rgb);
    splat_req_t r;
    r            = noise_req();
    r.req_type   = REQ_LOAD;
    r.tile_sel   = tile;
    r.texel_addr = addr;
    r.texel_rgb  = rgb;
    texel_loaded[{tile, addr}] = 1'b1;
    pending_reqs.push_back(r);
    queued_items++;
  endtask

  // a blend preceded by loads of every texel it would read that is still unwritten
  task automatic queue_blend(input logic [HEIGHT_W-1:0] hgt, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y);
    splat_req_t  r;
    int unsigned tw, th, addr;
    tw   = dim_limit(splat_cfg.tile_width);
    th   = dim_limit(splat_cfg.tile_height);
    addr = (y % th) * tw + (x % tw);
    for (int t = 0; t < active_tiles(); t++)
      if (!texel_loaded[t * TILE_ENTRIES + addr]) queue_load(t, addr, pick_rgb());
    r          = noise_req();
    r.req_type = REQ_BLEND;
    r.height   = hgt;
    r.pixel_x  = x;
    r.pixel_y  = y;
    pending_reqs.push_back(r);
    queued_items++;
  endtask

  // apb write: setup cycle, then access cycle; the register takes it at the end of access
  task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_NUM_TILES:   splat_cfg.num_tiles      = value[NT_W-1:0];
      REG_RANGE:       splat_cfg.range_per_tile = value[RANGE_W-1:0];
      REG_TILE_WIDTH:  splat_cfg.tile_width     = value[DIM_CFG_W-1:0];
      REG_TILE_HEIGHT: splat_cfg.tile_height    = value[DIM_CFG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input logic [NT_W-1:0] tiles, input logic [RANGE_W-1:0] rng,
                           input logic [DIM_CFG_W-1:0] w, input logic [DIM_CFG_W-1:0] h);
    write_reg(REG_NUM_TILES, APB_DW'(tiles));
    write_reg(REG_RANGE, APB_DW'(rng));
    write_reg(REG_TILE_WIDTH, APB_DW'(w));
    write_reg(REG_TILE_HEIGHT, APB_DW'(h));
    settings_applied++;
  endtask

  // every result back and the core idle; sampled away from the driving edge
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || start || busy || expected_pixels.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------
  splat_req_t active_req;
  int         gap_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      start     <= 1'b0;
      gap_count <= 0;
    end else begin
      // request taken at this edge: update the shadow store and line up its pixel
      if (start && !busy) begin
        if (active_req.req_type == REQ_LOAD) begin
          texel_store[{active_req.tile_sel, active_req.texel_addr}] = active_req.texel_rgb;
          loads_taken++;
        end else begin
          blends_taken++;
        end
        expected_pixels.push_back(predict_pixel(active_req));
      end
      // slot is free when nothing is offered or the offer was just taken
      if (!start || !busy) begin
        if (pending_reqs.size() != 0 && gap_count >= pending_reqs[0].gap) begin
          active_req     = pending_reqs.pop_front();
          start         <= 1'b1;
          in_req_type   <= active_req.req_type;
          in_tile_sel   <= active_req.tile_sel;
          in_texel_addr <= active_req.texel_addr;
          in_texel_rgb  <= active_req.texel_rgb;
          in_height     <= active_req.height;
          in_pixel_x    <= active_req.pixel_x;
          in_pixel_y    <= active_req.pixel_y;
          gap_count     <= 0;
        end else begin
          start <= 1'b0;
          // idle cycles count only once the core could take the next request
          if (pending_reqs.size() != 0 && !busy) gap_count <= gap_count + 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: every strobe is matched against the oldest prediction
  // ---------------------------------------------------------------------------
  splat_pixel_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: result with no request waiting, expected none, got rgb %06h status %0d",
                 $time, out_pixel_rgb, out_status);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        results_checked++;
        if (out_pixel_rgb !== want.rgb) begin
          $display("%0t: pixel_rgb mismatch, expected %06h, got %06h",
                   $time, want.rgb, out_pixel_rgb);
          mismatches++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, out_status);
          mismatches++;
        end
      end
    end
  end

  // hard stop if the core hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, expected_pixels.size());
      $display("height_blend_texture_splat_core test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int     tiles_n, tile, random_base;
    longint rng, lo, hgt;

    // register values after reset
    splat_cfg.num_tiles      = 3'd1;
    splat_cfg.range_per_tile = 24'd25600;
    splat_cfg.tile_width     = 7'd64;
    splat_cfg.tile_height    = 7'd64;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: one tile, band 0..99.0..199.0, 64x64 texels
    queue_load(2'd0, 12'd0, 24'hFFFFFF);
    queue_load(2'd3, 12'hFFF, 24'h000000);
    queue_load(2'd1, 12'd0, 24'h5AA55A);
    queue_load(2'd2, 12'hFFF, 24'hFFFFFF);
    queue_blend(24'd0, 16'd0, 16'd0);            // bottom of the band, zero weight
    queue_blend(24'd25344, 16'd0, 16'd0);        // optimal height, weight exactly one
    queue_blend(24'd12800, 16'd0, 16'd0);        // half way up the rising slope
    queue_blend(24'd50944, 16'd64, 16'd64);      // top of the band, coordinates wrap
    queue_blend(24'd38144, 16'd64, 16'd0);       // falling slope
    queue_blend(24'hFFFFFF, 16'hFFFF, 16'hFFFF); // far above the band, last texel
    wait_idle();

    // four tiles one unit wide: rising slope empty; zero-sized tiles act as 1x1
    apply_cfg(3'd4, 24'd256, 7'd0, 7'd0);
    queue_blend(24'd0, 16'hFFFF, 16'd0);
    queue_blend(24'd128, 16'd3, 16'd7);
    queue_blend(24'd256, 16'd0, 16'hFFFF);
    queue_blend(24'd767, 16'h1234, 16'h4321);
    wait_idle();

    // more tiles than the store holds, widest range, oversized tiles
    apply_cfg(3'd7, 24'hFFFFFF, 7'd127, 7'd65);
    queue_blend(24'hFFFFFF, 16'hFFFF, 16'hFFFF);
    queue_blend(24'd0, 16'd0, 16'd0);
    queue_blend(24'h800000, 16'h8000, 16'h0001);
    wait_idle();

    // no tiles at all and a zero range: the pixel is black
    apply_cfg(3'd0, 24'd0, 7'd1, 7'd1);
    queue_blend(24'h123456, 16'h00FF, 16'hFF00);
    queue_blend(24'd0, 16'd0, 16'd0);
    wait_idle();

    // random phases, each under fresh register settings
    random_base = queued_items;
    while (queued_items - random_base < RANDOM_ITEMS) begin
      tiles_n = ($urandom_range(0, 3) != 0) ? $urandom_range(1, MAX_TILES_DEF)
                                            : $urandom_range(0, 7);
      case ($urandom_range(0, 7))
        0:       rng = 0;
        1:       rng = 24'hFFFFFF;
        2:       rng = $urandom_range(1, ONE_Q8 - 1);
        3:       rng = ONE_Q8;
        4:       rng = ONE_Q8 + 1;
        5:       rng = $urandom_range(0, 24'hFFFFFF);
        default: rng = $urandom_range(2 * ONE_Q8, 64 * ONE_Q8);
      endcase
      apply_cfg(tiles_n, rng, pick_dim(), pick_dim());
      // some phases run back to back with no idle cycles at all
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 3) == 0) begin
          // stray load anywhere in the store
          queue_load($urandom_range(0, 3), $urandom_range(0, 4095), pick_rgb());
        end else begin
          // heights aimed at band edges and slopes of some tile
          tile = $urandom_range(0, MAX_TILES_DEF - 1);
          lo   = tile * rng;
          case ($urandom_range(0, 6))
            0:       hgt = lo;
            1:       hgt = lo + rng - ONE_Q8;
            2:       hgt = lo + 2 * rng - ONE_Q8;
            3:       hgt = lo + 2 * rng - ONE_Q8 + 1;
            4:       hgt = lo - 1;
            default: hgt = lo + $urandom_range(0, 32'(2 * rng));
          endcase
          if (hgt < 0 || hgt > longint'(24'hFFFFFF) || $urandom_range(0, 7) == 0)
            hgt = $urandom_range(0, 24'hFFFFFF);
          queue_blend(hgt[HEIGHT_W-1:0], pick_coord(), pick_coord());
        end
      end
      wait_idle();
    end

    // let any stray result show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("ran %0d texel loads and %0d blends under %0d register settings",
             loads_taken, blends_taken, settings_applied + 1);
    $display("checked %0d results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("height_blend_texture_splat_core test passed");
    end else begin
      $display("height_blend_texture_splat_core test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/hbts_pkg.sv
src/hbts_ram.sv
src/hbts_ctrl.sv
src/hbts_dp.sv
src/height_blend_texture_splat_core.sv
test/testbench.sv
